// ===== src/spq_pkg.sv =====
// Shared types, widths and codes for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;
	localparam int OCC_W     = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_DELETE  = 2'd1,
		CMD_DISPLAY = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DSEL_ZERO,
		DSEL_HEAD,
		DSEL_TAIL
	} dsel_t;

	typedef enum logic {
		S_IDLE,
		S_DISP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    ins;
		logic    del;
		logic    rot;
		logic    clr;
		logic    emit;
		status_t status;
		dsel_t   dsel;
		logic    last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic space;
		logic in_window;
		logic step_end;
	} dp_stat_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  data;
		logic        [OCC_W-1:0]   occupancy;
		logic                      last;
	} rsp_t;

endpackage

// ===== src/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
interface spq_cmd_if;
	logic                             valid;
	logic                             ready;
	logic        [spq_pkg::CMD_W-1:0]  command;
	logic signed [spq_pkg::DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface spq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic        [spq_pkg::STAT_W-1:0] status;
	logic signed [spq_pkg::DATA_W-1:0] data;
	logic        [spq_pkg::OCC_W-1:0]  occupancy;
	logic                              last;

	modport source (output valid, output status, output data, output occupancy, output last,
		input ready);
	modport sink   (input valid, input status, input data, input occupancy, input last,
		output ready);
endinterface

// ===== src/sorted_priority_queue_unit.sv =====
// Sorted min priority queue: top level joining controller, datapath and response buffer.
//
// Entries are held in a row of DEPTH registers kept sorted largest first and
// packed against the far end, so the minimum always sits in the last cell.
// Insert compares the new value against every cell at once and shifts the
// greater entries one place over; a value equal to stored ones goes in
// front of them. Delete-min takes the last cell and shifts the row the
// other way. Insert, delete, overflow, underflow and the reserved command
// code (no response) are all handled in the cycle the request is taken.
// Display streams entries largest first by rotating the whole row through
// its first cell: after the accept it rotates once per cell, holding while
// the response side stalls, and leaves the row as it found it.
// No new request is taken while a display runs. Responses go through a
// two-entry buffer, so a request is taken while the previous response still
// waits. After reset the queue is empty at once; the entry row needs no clearing.
module sorted_priority_queue_unit #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_cmd_if.sink   cmd_ch,
	spq_rsp_if.source rsp_ch
);

	spq_pkg::dp_cmd_t  dp_cmd;
	spq_pkg::dp_stat_t dp_stat;
	spq_pkg::rsp_t     rsp;
	logic              rsp_push;
	logic              buf_space;

	// request decode and display sequencing
	spq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (cmd_ch.valid),
		.req_command (cmd_ch.command),
		.req_ready   (cmd_ch.ready),
		.stat        (dp_stat),
		.cmd         (dp_cmd)
	);

	// sorted register row and counters
	spq_dpath #(.DEPTH(DEPTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.value     (cmd_ch.value),
		.stat      (dp_stat),
		.buf_space (buf_space),
		.rsp       (rsp),
		.rsp_push  (rsp_push)
	);

	// response skid buffer
	spq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rsp_push),
		.push_data (rsp),
		.space     (buf_space),
		.rsp_ch    (rsp_ch)
	);

	// never shift in when full, never shift out when empty
	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.ins |-> !dp_stat.full)
		else $error("insert issued on full queue");

	a_del_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.del |-> !dp_stat.empty)
		else $error("delete issued on empty queue");

	// a response is only produced when the buffer can take it
	a_emit_space: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.emit |-> dp_stat.space)
		else $error("response pushed into full buffer");

	// a display of a non-empty queue blocks the next request
	a_disp_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ch.valid && cmd_ch.ready && cmd_ch.command == spq_pkg::CMD_DISPLAY
			&& !dp_stat.empty) |=> !cmd_ch.ready)
		else $error("request taken during display");

endmodule

// ===== src/spq_obuf.sv =====
// Two-entry response buffer driving the response channel.
module spq_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spq_pkg::rsp_t     push_data,
	output logic              space,
	spq_rsp_if.source         rsp_ch
);

	spq_pkg::rsp_t head_q, tail_q;
	logic          head_vld_q, tail_vld_q;
	logic          pop;

	assign pop   = head_vld_q && rsp_ch.ready;
	assign space = !tail_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else if (!head_vld_q || pop) begin
			if (tail_vld_q) begin
				head_vld_q <= 1'b1;
				tail_vld_q <= push;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			tail_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_vld_q || pop) begin
			if (tail_vld_q) begin
				head_q <= tail_q;
				if (push) tail_q <= push_data;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			tail_q <= push_data;
		end
	end

	assign rsp_ch.valid     = head_vld_q;
	assign rsp_ch.status    = head_q.status;
	assign rsp_ch.data      = head_q.data;
	assign rsp_ch.occupancy = head_q.occupancy;
	assign rsp_ch.last      = head_q.last;

endmodule

// ===== src/spq_dpath.sv =====
// Datapath: right-aligned sorted register row, entry count, display step counter.
module spq_dpath #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::dp_cmd_t                  cmd,
	input  logic signed [spq_pkg::DATA_W-1:0] value,
	output spq_pkg::dp_stat_t                 stat,
	input  logic                              buf_space,
	output spq_pkg::rsp_t                     rsp,
	output logic                              rsp_push
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	// Smallest entry lives in the last cell, largest at DEPTH-count.
	logic signed [spq_pkg::DATA_W-1:0] entry_q [DEPTH];
	logic        [CNT_W-1:0]           count_q, count_d;
	logic        [IDX_W-1:0]           step_q;
	logic        [DEPTH-1:0]           vld, gt;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vld[i] = count_q >= CNT_W'(DEPTH - i);
			gt[i]  = vld[i] && (entry_q[i] > value);
		end
	end

	// Per-cell update: insert shifts greater entries left, delete shifts right,
	// rotate moves every cell left by one with wraparound.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic up_gt;
		logic signed [spq_pkg::DATA_W-1:0] up_ent, dn_ent;
		if (i < DEPTH - 1) begin : g_up
			assign up_gt  = gt[i+1];
			assign up_ent = entry_q[i+1];
		end else begin : g_wrap
			assign up_gt  = 1'b0;
			assign up_ent = entry_q[0];
		end
		if (i > 0) begin : g_dn
			assign dn_ent = entry_q[i-1];
		end else begin : g_dn0
			assign dn_ent = entry_q[0];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (up_gt) entry_q[i] <= up_ent;
				else if (gt[i] || !vld[i]) entry_q[i] <= value;
			end else if (cmd.del) begin
				entry_q[i] <= dn_ent;
			end else if (cmd.rot) begin
				entry_q[i] <= up_ent;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins) count_d = count_q + 1'b1;
		else if (cmd.del) count_d = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q  <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.clr) step_q <= '0;
			else if (cmd.rot) step_q <= stat.step_end ? '0 : step_q + 1'b1;
		end
	end

	assign stat.full      = count_q == CNT_W'(DEPTH);
	assign stat.empty     = count_q == '0;
	assign stat.space     = buf_space;
	assign stat.in_window = CNT_W'(step_q) >= (CNT_W'(DEPTH) - count_q);
	assign stat.step_end  = step_q == IDX_W'(DEPTH - 1);

	always_comb begin
		rsp.status    = cmd.status;
		rsp.occupancy = spq_pkg::OCC_W'(count_d);
		rsp.last      = cmd.last;
		unique case (cmd.dsel)
			spq_pkg::DSEL_HEAD: rsp.data = entry_q[0];
			spq_pkg::DSEL_TAIL: rsp.data = entry_q[DEPTH-1];
			default:            rsp.data = '0;
		endcase
	end

	assign rsp_push = cmd.emit;

endmodule

// ===== src/spq_ctrl.sv =====
// Controller: request decode and display sequencing.
module spq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [spq_pkg::CMD_W-1:0]       req_command,
	output logic                            req_ready,
	input  spq_pkg::dp_stat_t               stat,
	output spq_pkg::dp_cmd_t                cmd
);

	spq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spq_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		cmd.status = spq_pkg::ST_OK;
		cmd.dsel   = spq_pkg::DSEL_ZERO;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				req_ready = stat.space;
				if (req_valid && stat.space) begin
					cmd.last = 1'b1;
					case (req_command)
						spq_pkg::CMD_INSERT: begin
							cmd.emit = 1'b1;
							if (stat.full) cmd.status = spq_pkg::ST_OVERFLOW;
							else           cmd.ins    = 1'b1;
						end
						spq_pkg::CMD_DELETE: begin
							cmd.emit = 1'b1;
							if (stat.empty) begin
								cmd.status = spq_pkg::ST_UNDERFLOW;
							end else begin
								cmd.del  = 1'b1;
								cmd.dsel = spq_pkg::DSEL_TAIL;
							end
						end
						spq_pkg::CMD_DISPLAY: begin
							if (stat.empty) begin
								cmd.emit   = 1'b1;
								cmd.status = spq_pkg::ST_EMPTY;
							end else begin
								cmd.clr = 1'b1;
								state_d = spq_pkg::S_DISP;
							end
						end
						default: ;
					endcase
				end
			end
			spq_pkg::S_DISP: begin
				if (!stat.in_window) begin
					cmd.rot = 1'b1;
				end else if (stat.space) begin
					cmd.rot  = 1'b1;
					cmd.emit = 1'b1;
					cmd.dsel = spq_pkg::DSEL_HEAD;
					cmd.last = stat.step_end;
					if (stat.step_end) state_d = spq_pkg::S_IDLE;
				end
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

endmodule
